// File: rtl/linear_interp_resampler_unit_assert.svh
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Assertion macros used by the resampler top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("resampler check failed");

// Next-cycle implication, checked outside reset.
`define LIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("resampler check failed");

`endif

// File: rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Lane count, sample width, register indexes and the issue control passed
// from the sequencer.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int LIR_LANES       = 8;
   localparam int LIR_SAMPLE_BITS = 24;

   typedef logic [LIR_SAMPLE_BITS-1:0] lir_sample_type;

   typedef enum logic [1:0] {
      REG_STEP_SIZE   = 2'd0,
      REG_PASSTHROUGH = 2'd1,
      REG_CHANNELS    = 2'd2
   } lir_reg_type;

   typedef struct packed {
      logic valid;
      logic last;
   } lir_issue_type;

endpackage

// File: rtl/lir_lane.sv
// ----------------------------------------------------------------------------
// Resampler interpolation lane
// Multiplies the fraction by the sample difference and adds it to the base.
// ----------------------------------------------------------------------------
module lir_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic [lir_pkg::LIR_SAMPLE_BITS-1:0] base,
   input  logic [lir_pkg::LIR_SAMPLE_BITS-1:0] target,
   input  logic [FRAC_BITS-1:0]               frac,
   output logic [lir_pkg::LIR_SAMPLE_BITS-1:0] result
);
   import lir_pkg::*;

   localparam int SB = LIR_SAMPLE_BITS;
   localparam int PB = SB + FRAC_BITS + 2;

   logic signed [SB:0]   diff;
   logic signed [PB-1:0] prod;
   logic signed [PB-1:0] prod_ff;
   logic [SB-1:0]        base_ff;
   logic signed [PB-1:0] shifted;
   logic signed [PB-1:0] sum;

   assign diff = $signed({target[SB-1], target}) - $signed({base[SB-1], base});
   assign prod = $signed({1'b0, frac}) * diff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod;
         base_ff <= base;
      end
   end

   assign shifted = prod_ff >>> FRAC_BITS;
   assign sum     = $signed({{(PB-SB){base_ff[SB-1]}}, base_ff}) + shifted;
   assign result  = sum[SB-1:0];

endmodule

// File: rtl/lir_merge.sv
// ----------------------------------------------------------------------------
// Resampler merge stage
// Tracks the lane pipeline, masks inactive lanes and holds the response.
// ----------------------------------------------------------------------------
module lir_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  lir_pkg::lir_issue_type                          issue,
   output logic                                            s1_ready,
   input  logic [lir_pkg::LIR_LANES-1:0][lir_pkg::LIR_SAMPLE_BITS-1:0] lane_y,
   input  logic [3:0]                                      channels_in_use,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic [lir_pkg::LIR_LANES-1:0][lir_pkg::LIR_SAMPLE_BITS-1:0] rsp_data,
   output logic                                            rsp_last
);
   import lir_pkg::*;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s1_last_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_last_ff;
   logic s2_load;
   logic fire;
   logic [LIR_LANES-1:0][LIR_SAMPLE_BITS-1:0] masked;
   logic [LIR_LANES-1:0][LIR_SAMPLE_BITS-1:0] data_ff;

   assign s2_load  = !rsp_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_load;
   assign fire     = issue.valid && s1_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (fire) begin
         s1_valid_in = 1'b1;
      end
      for (int i = 0; i < LIR_LANES; i++) begin
         masked[i] = (i < int'(channels_in_use)) ? lane_y[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         s1_last_ff <= issue.last;
      end
      if (s2_load && s1_valid_ff) begin
         data_ff     <= masked;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// File: rtl/linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Converts multichannel frames between sample rates by linear interpolation.
//
//   Channel   Direction  Ports                           Moves
//   req       in         req_valid/req_ready/req_sample  one input frame
//   rsp       out        rsp_valid/rsp_ready/rsp_out     one output frame
//   csr       in/out     psel/penable/pwrite/paddr/...   register access
//
// An input frame yielding n output frames occupies the sequencer for its
// accept, one issue per output frame into the shared eight-lane multiply
// pipeline (held by a stall) and a close step; a priming frame needs only
// the accept, a passthrough frame one issue more. Issues register in the
// lanes, then in the merge. Reset is synchronous and needs no clearing pass.
// A low rsp_ready stalls the lane pipeline and then the sequencer.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit #(
   parameter int FRAC_BITS    = 16,
   parameter int MAX_UPSAMPLE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_sample_0,
   input  logic [23:0] req_sample_1,
   input  logic [23:0] req_sample_2,
   input  logic [23:0] req_sample_3,
   input  logic [23:0] req_sample_4,
   input  logic [23:0] req_sample_5,
   input  logic [23:0] req_sample_6,
   input  logic [23:0] req_sample_7,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_out_0,
   output logic [23:0] rsp_out_1,
   output logic [23:0] rsp_out_2,
   output logic [23:0] rsp_out_3,
   output logic [23:0] rsp_out_4,
   output logic [23:0] rsp_out_5,
   output logic [23:0] rsp_out_6,
   output logic [23:0] rsp_out_7,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lir_pkg::*;

   localparam int PW = FRAC_BITS + 4;
   localparam int CW = $clog2(MAX_UPSAMPLE + 1);
   localparam logic [PW:0]   PHASE_ONE = (PW+1)'(1) << FRAC_BITS;
   localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_UPSAMPLE);
   localparam logic [CW-1:0] CNT_LAST  = CW'(MAX_UPSAMPLE - 1);

   typedef enum logic [1:0] {IDLE, PASS, RUN} state_type;

   state_type      state_ff;
   logic [PW-1:0]  step_ff;
   logic           pass_ff;
   logic [3:0]     chan_ff;
   logic [PW-1:0]  phase_ff;
   logic           primed_ff;
   logic [PW:0]    ph_ff;
   logic [CW-1:0]  cnt_ff;
   lir_sample_type x_ff    [LIR_LANES];
   lir_sample_type prev_ff [LIR_LANES];
   lir_sample_type samples [LIR_LANES];

   logic           csr_write;
   logic           req_fire;
   logic           run_more;
   logic [PW:0]    ph_sum;
   logic [PW:0]    ph_dec;
   logic           s1_ready;
   logic           issue_fire;
   lir_issue_type  issue;
   logic [FRAC_BITS-1:0] lane_frac;
   logic [LIR_LANES-1:0][LIR_SAMPLE_BITS-1:0] lane_y;
   logic [LIR_LANES-1:0][LIR_SAMPLE_BITS-1:0] rsp_data;

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;
   assign samples[7] = req_sample_7;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= PHASE_ONE[PW-1:0];
         pass_ff <= 1'b0;
         chan_ff <= 4'd2;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_STEP_SIZE:   step_ff <= pwdata[PW-1:0];
            REG_PASSTHROUGH: pass_ff <= pwdata[0];
            REG_CHANNELS:    chan_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_STEP_SIZE:   prdata = {{(32-PW){1'b0}}, step_ff};
         REG_PASSTHROUGH: prdata = {31'd0, pass_ff};
         REG_CHANNELS:    prdata = {28'd0, chan_ff};
         default:         prdata = '0;
      endcase
   end

   assign req_ready  = (state_ff == IDLE);
   assign req_fire   = req_valid && req_ready;
   assign run_more   = (ph_ff < PHASE_ONE) && (cnt_ff < CNT_MAX);
   assign ph_sum     = ph_ff + {1'b0, step_ff};
   assign ph_dec     = ph_ff - PHASE_ONE;
   assign issue.valid = (state_ff == PASS) || ((state_ff == RUN) && run_more);
   assign issue.last  = (state_ff == PASS) || (ph_sum >= PHASE_ONE) || (cnt_ff == CNT_LAST);
   assign issue_fire  = issue.valid && s1_ready;
   assign lane_frac   = (state_ff == PASS) ? '0 : ph_ff[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         phase_ff  <= '0;
         primed_ff <= 1'b0;
         ph_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  x_ff   <= samples;
                  ph_ff  <= {1'b0, phase_ff};
                  cnt_ff <= '0;
                  if (pass_ff) begin
                     prev_ff   <= samples;
                     primed_ff <= 1'b1;
                     state_ff  <= PASS;
                  end else if (!primed_ff) begin
                     prev_ff   <= samples;
                     primed_ff <= 1'b1;
                  end else begin
                     state_ff <= RUN;
                  end
               end
            end
            PASS: begin
               if (s1_ready) begin
                  state_ff <= IDLE;
               end
            end
            RUN: begin
               if (run_more) begin
                  if (s1_ready) begin
                     ph_ff  <= ph_sum;
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end else begin
                  phase_ff <= (ph_ff >= PHASE_ONE) ? ph_dec[PW-1:0] : '0;
                  prev_ff  <= x_ff;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   for (genvar g = 0; g < LIR_LANES; g++) begin : g_lane
      lir_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .load   (issue_fire),
         .base   ((state_ff == PASS) ? x_ff[g] : prev_ff[g]),
         .target (x_ff[g]),
         .frac   (lane_frac),
         .result (lane_y[g])
      );
   end

   lir_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .issue           (issue),
      .s1_ready        (s1_ready),
      .lane_y          (lane_y),
      .channels_in_use (chan_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_last        (rsp_last_of_run)
   );

   assign rsp_out_0 = rsp_data[0];
   assign rsp_out_1 = rsp_data[1];
   assign rsp_out_2 = rsp_data[2];
   assign rsp_out_3 = rsp_data[3];
   assign rsp_out_4 = rsp_data[4];
   assign rsp_out_5 = rsp_data[5];
   assign rsp_out_6 = rsp_data[6];
   assign rsp_out_7 = rsp_data[7];

`include "linear_interp_resampler_unit_assert.svh"

   `LIR_ASSERT_NOW(a_count_bound, clock, reset, state_ff == RUN, cnt_ff <= CNT_MAX)
   `LIR_ASSERT_NOW(a_pass_last, clock, reset, state_ff == PASS, issue.valid && issue.last)
   `LIR_ASSERT_NEXT(a_pass_entry, clock, reset, req_fire && pass_ff, state_ff == PASS)
   `LIR_ASSERT_NEXT(a_run_close, clock, reset, state_ff == RUN && !run_more,
                    state_ff == IDLE && primed_ff)

endmodule
